// ----- rtl/core/twtt_pkg.sv -----
// Shared constants, codes and entry layout for the two-way transposition table.
package twtt_pkg;

  localparam int CLUSTERS = 4096;
  localparam int WAYS     = 2;
  localparam int IDX_W    = $clog2(CLUSTERS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int KEY_W    = 64;
  localparam int MOVE_W   = 16;
  localparam int SCORE_W  = 16;
  localparam int DIN_W    = 11;
  localparam int DEPTH_W  = 8;
  localparam int BOUND_W  = 2;
  localparam int AGE_W    = 8;
  localparam int PRIO_W   = 22;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 48;

  localparam logic signed [PRIO_W-1:0] PRIO_EMPTY = -PRIO_W'(1000000);
  localparam logic signed [PRIO_W-1:0] AGE_BONUS  = PRIO_W'(200);
  localparam logic signed [DIN_W-1:0]  DEPTH_MIN  = -DIN_W'(127);
  localparam logic signed [DIN_W-1:0]  DEPTH_MAX  = DIN_W'(127);

  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_STORE  = 2'd1,
    OP_NEWGEN = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [BOUND_W-1:0] BND_NONE  = 2'd0;
  localparam logic [BOUND_W-1:0] BND_EXACT = 2'd1;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic signed [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0]        bound;
    logic [AGE_W-1:0]          age;
  } entry_t;

  localparam int ROW_W = WAYS * $bits(entry_t);

endpackage

// ----- rtl/core/twtt_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module twtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/two_way_transposition_table.sv -----
// Two-way transposition table: probe, store, new search and clear on one stream.
//
// Each cluster of two entries is one row of a single RAM indexed by the low key bits.
// A probe, store or new search reads the cluster row in the cycle it is accepted;
// the row is compared and, once the output register is free, the result is
// registered and a probe hit or an unskipped store writes the row back updated.
// A clear, and the period after reset, sweeps the RAM one row per cycle, accepting
// no input transaction; the result of a clear transaction is issued when the sweep
// starts. One result transaction is produced for every input transaction.
module two_way_transposition_table
  import twtt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // key[63:0], move_in[79:64], score_in[95:80], depth_in[106:96], bound_in[108:107]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // move_out[15:0], score_out[31:16], depth_out[39:32], bound_out[41:40]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // hit[0]
  output logic                   out_tuser
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC
  } state_t;

  state_t                     state_r;
  logic [IDX_W-1:0]           clr_idx_r;
  logic [AGE_W-1:0]           gen_r;

  op_t                        req_op_r;
  logic [KEY_W-1:0]           req_key_r;
  logic [MOVE_W-1:0]          req_move_r;
  logic signed [SCORE_W-1:0]  req_score_r;
  logic signed [DIN_W-1:0]    req_depth_r;
  logic [BOUND_W-1:0]         req_bound_r;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [MOVE_W-1:0]          out_move_r;
  logic signed [SCORE_W-1:0]  out_score_r;
  logic signed [DEPTH_W-1:0]  out_depth_r;
  logic [BOUND_W-1:0]         out_bound_r;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [ROW_W-1:0]           ram_wdata;
  logic [IDX_W-1:0]           ram_raddr;
  logic [ROW_W-1:0]           ram_rdata;

  entry_t [WAYS-1:0]          row_cur;
  entry_t [WAYS-1:0]          row_new;
  logic                       hit_found;
  logic [WAY_W-1:0]           hit_way;
  logic                       same_found;
  logic [WAY_W-1:0]           sel_way;
  logic signed [PRIO_W-1:0]   worst;
  logic signed [PRIO_W-1:0]   prio;
  logic                       skip;
  logic signed [DEPTH_W-1:0]  depth_sat;
  logic                       advance;
  logic                       in_acc;
  logic                       probe_hit;

  function automatic logic signed [PRIO_W-1:0] way_prio(input entry_t e,
                                                        input logic [AGE_W-1:0] g);
    logic signed [PRIO_W-1:0] p;
    p = {{(PRIO_W-DEPTH_W){e.depth[DEPTH_W-1]}}, e.depth};
    if (e.age == g) begin
      p = p + AGE_BONUS;
    end
    if (e.bound == BND_NONE) begin
      p = PRIO_EMPTY;
    end
    return p;
  endfunction

  twtt_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CLUSTERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign advance    = (state_r == S_CALC) && (!out_valid_r || out_tready);
  assign ram_raddr  = (state_r == S_IDLE) ? in_tdata[IDX_W-1:0] : req_key_r[IDX_W-1:0];
  assign row_cur    = ram_rdata;
  assign probe_hit  = (req_op_r == OP_PROBE) && hit_found;

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    same_found = 1'b0;
    sel_way    = '0;
    worst      = way_prio(row_cur[0], gen_r);
    prio       = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit_found && row_cur[i].key == req_key_r && row_cur[i].bound != BND_NONE) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      prio = way_prio(row_cur[i], gen_r);
      if (!same_found) begin
        if (row_cur[i].key == req_key_r) begin
          same_found = 1'b1;
          sel_way    = WAY_W'(i);
        end else if (prio < worst) begin
          sel_way = WAY_W'(i);
          worst   = prio;
        end
      end
    end

    skip = (row_cur[sel_way].key == req_key_r) &&
           (row_cur[sel_way].bound == BND_EXACT) &&
           ($signed({{(DIN_W-DEPTH_W){row_cur[sel_way].depth[DEPTH_W-1]}},
                     row_cur[sel_way].depth}) > req_depth_r);

    if (req_depth_r < DEPTH_MIN) begin
      depth_sat = DEPTH_MIN[DEPTH_W-1:0];
    end else if (req_depth_r > DEPTH_MAX) begin
      depth_sat = DEPTH_MAX[DEPTH_W-1:0];
    end else begin
      depth_sat = req_depth_r[DEPTH_W-1:0];
    end

    row_new = row_cur;
    if (req_op_r == OP_PROBE) begin
      row_new[hit_way].age = gen_r;
    end else begin
      row_new[sel_way].key   = req_key_r;
      row_new[sel_way].move  = req_move_r;
      row_new[sel_way].score = req_score_r;
      row_new[sel_way].depth = depth_sat;
      row_new[sel_way].bound = req_bound_r;
      row_new[sel_way].age   = gen_r;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_key_r[IDX_W-1:0];
    ram_wdata = row_new;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
      end
      S_CALC: begin
        ram_we = advance && (((req_op_r == OP_PROBE) && hit_found) ||
                             ((req_op_r == OP_STORE) && !skip));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !advance) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == IDX_W'(CLUSTERS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (advance) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= probe_hit;
            out_move_r  <= probe_hit ? row_cur[hit_way].move  : '0;
            out_score_r <= probe_hit ? row_cur[hit_way].score : '0;
            out_depth_r <= probe_hit ? row_cur[hit_way].depth : '0;
            out_bound_r <= probe_hit ? row_cur[hit_way].bound : '0;
            state_r     <= (req_op_r == OP_CLEAR) ? S_CLEAR : S_IDLE;
            case (req_op_r)
              OP_NEWGEN: begin
                gen_r <= gen_r + 1'b1;
              end
              OP_CLEAR: begin
                gen_r     <= '0;
                clr_idx_r <= '0;
              end
              default: begin
                gen_r <= gen_r;
              end
            endcase
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op_r    <= op_t'(in_tuser);
      req_key_r   <= in_tdata[63:0];
      req_move_r  <= in_tdata[79:64];
      req_score_r <= in_tdata[95:80];
      req_depth_r <= in_tdata[106:96];
      req_bound_r <= in_tdata[108:107];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(OUT_TDATA_W-42){1'b0}}, out_bound_r, out_depth_r,
                       out_score_r, out_move_r};

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram_we)
    else $error("RAM written while idle");

  a_gen_zero_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> gen_r == '0)
    else $error("generation not zero during clear sweep");

  a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> out_bound_r != BND_NONE)
    else $error("hit reported with empty bound");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_tdata == '0)
    else $error("miss result carries data");

endmodule

// ----- tb/twtt_checker.sv -----
// Checker for the two-way transposition table: tracks the table contents and compares results.
module twtt_checker
  import twtt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic signed [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0]        bound;
    logic [AGE_W-1:0]          age;
  } slot_t;

  typedef struct {
    logic                      hit;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic signed [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0]        bound;
  } lookup_t;

  slot_t        slots [CLUSTERS][WAYS];
  logic [AGE_W-1:0] search_gen;
  lookup_t      lookups_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic wipe_table();
    for (int c = 0; c < CLUSTERS; c++) begin
      for (int w = 0; w < WAYS; w++) begin
        slots[c][w] = '{default: '0};
      end
    end
    search_gen = '0;
  endtask

  function automatic int replace_rank(slot_t s, logic [AGE_W-1:0] g);
    if (s.bound == BND_NONE) return int'(PRIO_EMPTY);
    return int'(s.depth) + ((s.age == g) ? int'(AGE_BONUS) : 0);
  endfunction

  task automatic run_command(input logic [1:0] op, input logic [IN_TDATA_W-1:0] d,
                             output lookup_t r);
    logic [KEY_W-1:0] k;
    int idx;
    int sel;
    int worst;
    int p;
    int dreq;
    int dsat;
    k = d[63:0];
    idx = int'(k[IDX_W-1:0]);
    r = '{default: '0};
    case (op_t'(op))
      OP_PROBE: begin
        for (int w = 0; w < WAYS; w++) begin
          if (slots[idx][w].key == k && slots[idx][w].bound != BND_NONE) begin
            slots[idx][w].age = search_gen;
            r.hit = 1'b1;
            r.move = slots[idx][w].move;
            r.score = slots[idx][w].score;
            r.depth = slots[idx][w].depth;
            r.bound = slots[idx][w].bound;
            break;
          end
        end
      end
      OP_STORE: begin
        dreq = int'($signed(d[106:96]));
        sel = 0;
        worst = replace_rank(slots[idx][0], search_gen);
        for (int w = 0; w < WAYS; w++) begin
          if (slots[idx][w].key == k) begin
            sel = w;
            break;
          end
          p = replace_rank(slots[idx][w], search_gen);
          if (p < worst) begin
            sel = w;
            worst = p;
          end
        end
        if (!(slots[idx][sel].key == k && int'(slots[idx][sel].depth) > dreq &&
              slots[idx][sel].bound == BND_EXACT)) begin
          dsat = dreq < int'(DEPTH_MIN) ? int'(DEPTH_MIN) :
                 (dreq > int'(DEPTH_MAX) ? int'(DEPTH_MAX) : dreq);
          slots[idx][sel].key = k;
          slots[idx][sel].move = d[79:64];
          slots[idx][sel].score = d[95:80];
          slots[idx][sel].depth = DEPTH_W'(dsat);
          slots[idx][sel].bound = d[108:107];
          slots[idx][sel].age = search_gen;
        end
      end
      OP_NEWGEN: begin
        search_gen = search_gen + 1'b1;
      end
      default: begin
        wipe_table();
      end
    endcase
  endtask

  always @(posedge clk) begin
    lookup_t want;
    lookup_t got;
    if (!rst_n) begin
      wipe_table();
      lookups_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        run_command(in_tuser, in_tdata, want);
        lookups_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.hit = out_tuser;
        got.move = out_tdata[15:0];
        got.score = out_tdata[31:16];
        got.depth = out_tdata[39:32];
        got.bound = out_tdata[41:40];
        if (lookups_due.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_count++;
        end else begin
          want = lookups_due.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            fail_count++;
          end
          if (got.move !== want.move) begin
            $error("move_out: expected %0h, got %0h", want.move, got.move);
            fail_count++;
          end
          if (got.score !== want.score) begin
            $error("score_out: expected %0d, got %0d", want.score, got.score);
            fail_count++;
          end
          if (got.depth !== want.depth) begin
            $error("depth_out: expected %0d, got %0d", want.depth, got.depth);
            fail_count++;
          end
          if (got.bound !== want.bound) begin
            $error("bound_out: expected %0d, got %0d", want.bound, got.bound);
            fail_count++;
          end
        end
      end
    end
    pending <= lookups_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top-level testbench for the two-way transposition table: stimulus, handshakes and verdict.
module tb_top;
  import twtt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT   = 1250;
  localparam int RANDOM_COUNT = ITEM_COUNT - 282;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN        = 20;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_LOW  = 64'h0000_0000_0000_0FFF;
  localparam logic [KEY_W-1:0] KEY_ALT  = 64'hAAAA_AAAA_AAAA_AFFF;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = OP_PROBE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  int                     fail_count;
  int                     pending;
  int                     cycles = 0;
  int                     sent = 0;
  logic [KEY_W-1:0]       key_pool [16];

  two_way_transposition_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  twtt_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int gap_length(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = gap_length((cycles / 400) % 4 == 3);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_cmd(input op_t op, input logic [KEY_W-1:0] k,
                          input logic [MOVE_W-1:0] mv, input logic [SCORE_W-1:0] sc,
                          input logic [DIN_W-1:0] dp, input logic [BOUND_W-1:0] bd);
    int gap;
    gap = gap_length(sent % 200 >= 150);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, bd, dp, sc, mv, k};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  function automatic logic [DIN_W-1:0] rand_depth();
    int t;
    if ($urandom_range(0, 9) < 2) return DIN_W'($urandom);
    t = int'($urandom_range(0, 150)) - 20;
    return DIN_W'(t);
  endfunction

  function automatic op_t rand_op();
    int r;
    r = $urandom_range(0, 999);
    if (r < 400) return OP_PROBE;
    if (r < 850) return OP_STORE;
    if (r < 990) return OP_NEWGEN;
    return OP_CLEAR;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 15)];
    return {$urandom, $urandom};
  endfunction

  task automatic send_random(input op_t op);
    send_cmd(op, rand_key(), MOVE_W'($urandom), SCORE_W'($urandom), rand_depth(),
             BOUND_W'($urandom_range(0, 3)));
  endtask

  initial begin
    logic [IDX_W-1:0] hot [4];
    hot[0] = '0;
    hot[1] = '1;
    hot[2] = IDX_W'($urandom);
    hot[3] = IDX_W'($urandom);
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][IDX_W-1:0] = hot[i / 4];
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, then a store that leaves the way counted as empty.
    send_cmd(OP_PROBE, '0, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    send_cmd(OP_STORE, '0, 16'h1234, 16'sh0042, 11'sd0, BND_NONE);
    send_cmd(OP_PROBE, '0, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    // Field extremes with depth saturation; deeper exact entries resist overwrite.
    send_cmd(OP_STORE, KEY_ONES, 16'hFFFF, 16'sh8000, 11'sd1023, BND_EXACT);
    send_cmd(OP_PROBE, KEY_ONES, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    send_cmd(OP_STORE, KEY_ONES, 16'h0001, 16'sh0001, 11'sd5, 2'd2);
    send_cmd(OP_STORE, KEY_ONES, 16'h0002, 16'sh0002, -11'sd1024, BND_EXACT);
    send_cmd(OP_PROBE, KEY_ONES, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    // Same cluster, other keys: fill the empty way, then evict the shallower one.
    send_cmd(OP_STORE, KEY_LOW, 16'h0000, 16'sh7FFF, -11'sd1024, 2'd3);
    send_cmd(OP_PROBE, KEY_LOW, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    send_cmd(OP_STORE, KEY_ALT, 16'hA5A5, -16'sd7, 11'sd300, 2'd2);
    send_cmd(OP_PROBE, KEY_LOW, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    // A new search makes the unrefreshed way the victim.
    send_cmd(OP_NEWGEN, KEY_LOW, 16'hFFFF, 16'sh7FFF, 11'sd1023, 2'd3);
    send_cmd(OP_PROBE, KEY_ONES, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    send_cmd(OP_STORE, KEY_LOW, 16'h5A5A, 16'sd100, 11'sd10, BND_EXACT);
    send_cmd(OP_PROBE, KEY_ALT, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    send_cmd(OP_STORE, KEY_LOW, 16'h0BAD, 16'sd1, 11'sd3, BND_EXACT);
    send_cmd(OP_STORE, KEY_LOW, 16'h0C0D, 16'sd2, 11'sd10, 2'd3);
    send_cmd(OP_PROBE, KEY_LOW, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    send_cmd(OP_CLEAR, KEY_ALT, 16'hFFFF, 16'sh8000, -11'sd1024, 2'd3);
    send_cmd(OP_PROBE, KEY_ONES, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);
    send_cmd(OP_PROBE, KEY_LOW, 16'h0000, 16'sh0000, 11'sd0, BND_NONE);

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n == RANDOM_COUNT / 2) begin
        // Enough new searches to wrap the generation counter.
        repeat (256 + $urandom_range(0, 8)) send_random(OP_NEWGEN);
      end
      send_random(rand_op());
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/twtt_pkg.sv
rtl/core/twtt_ram.sv
rtl/core/two_way_transposition_table.sv
tb/twtt_checker.sv
tb/tb_top.sv
